// File: hdl/dtpv_pkg.sv
// shared types, character codes and calendar tables of the timestamp parser
package dtpv_pkg;

  // ascii codes of the expected characters
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // character positions in YYYY-MM-DD/HH:MM
  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] POS_YEAR_HI_END = 5'd1;
  localparam logic [POS_W-1:0] POS_YEAR_END    = 5'd3;
  localparam logic [POS_W-1:0] POS_DASH_A      = 5'd4;
  localparam logic [POS_W-1:0] POS_MONTH_END   = 5'd6;
  localparam logic [POS_W-1:0] POS_DASH_B      = 5'd7;
  localparam logic [POS_W-1:0] POS_DAY_END     = 5'd9;
  localparam logic [POS_W-1:0] POS_SLASH       = 5'd10;
  localparam logic [POS_W-1:0] POS_HOUR_END    = 5'd12;
  localparam logic [POS_W-1:0] POS_COLON       = 5'd13;
  localparam logic [POS_W-1:0] POS_FINAL       = 5'd15;
  localparam logic [POS_W-1:0] POS_TEXT_LEN    = 5'd16;
  localparam logic [POS_W-1:0] POS_SAT         = 5'd17;

  // calendar limits
  localparam logic [13:0] YEAR_MIN   = 14'd1000;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [6:0]  MONTH_MAX  = 7'd12;
  localparam logic [6:0]  HOUR_LIM   = 7'd24;
  localparam logic [6:0]  MINUTE_LIM = 7'd60;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;

  // widths of the result stream
  localparam int unsigned OUT_DATA_W = 40;

  // field snapshot handed from the parser to the checker
  typedef struct packed {
    logic        fmt_ok;
    logic        len_ok;
    logic [13:0] year;
    logic [6:0]  year_hi;
    logic [6:0]  year_lo;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
  } fields_t;

  // one result item
  typedef struct packed {
    logic        valid_res;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } result_t;

  // acc * 10 + d, kept to 7 bits
  function automatic logic [6:0] add_digit7(input logic [6:0] acc, input logic [3:0] d);
    logic [9:0] t;
    t = {acc, 3'b000} + {2'b00, acc, 1'b0} + {6'd0, d};
    return t[6:0];
  endfunction

  // acc * 10 + d, kept to 14 bits
  function automatic logic [13:0] add_digit14(input logic [13:0] acc, input logic [3:0] d);
    logic [16:0] t;
    t = {acc, 3'b000} + {2'b00, acc, 1'b0} + {13'd0, d};
    return t[13:0];
  endfunction

  // days in a month, zero for codes that are no month
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd1:    n = 5'd31;
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd3:    n = 5'd31;
      4'd4:    n = 5'd30;
      4'd5:    n = 5'd31;
      4'd6:    n = 5'd30;
      4'd7:    n = 5'd31;
      4'd8:    n = 5'd31;
      4'd9:    n = 5'd30;
      4'd10:   n = 5'd31;
      4'd11:   n = 5'd30;
      4'd12:   n = 5'd31;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

// File: hdl/dtpv_parse.sv
// per-character format check and decimal field accumulation
module dtpv_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [7:0]       char_code,
  input  logic             last_char,
  output dtpv_pkg::fields_t fields
);
  import dtpv_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             fmt_r, fmt_nxt;
  logic [13:0]      year_r, year_nxt;
  logic [6:0]       yhi_r, yhi_nxt;
  logic [6:0]       ylo_r, ylo_nxt;
  logic [6:0]       month_r, month_nxt;
  logic [6:0]       day_r, day_nxt;
  logic [6:0]       hour_r, hour_nxt;
  logic [6:0]       minute_r, minute_nxt;

  logic             digit;
  logic [3:0]       dval;
  logic [7:0]       dfull;
  logic             fmt_upd;
  logic [13:0]      year_upd;
  logic [6:0]       yhi_upd, ylo_upd, month_upd, day_upd, hour_upd, minute_upd;

  // digit decode
  assign digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign dfull = char_code - CHAR_ZERO;
  assign dval  = dfull[3:0];

  // effect of one character on the state
  always_comb begin
    fmt_upd    = fmt_r;
    year_upd   = year_r;
    yhi_upd    = yhi_r;
    ylo_upd    = ylo_r;
    month_upd  = month_r;
    day_upd    = day_r;
    hour_upd   = hour_r;
    minute_upd = minute_r;
    if (pos_r <= POS_YEAR_END) begin
      if (digit) begin
        year_upd = add_digit14(year_r, dval);
        if (pos_r <= POS_YEAR_HI_END) begin
          yhi_upd = add_digit7(yhi_r, dval);
        end else begin
          ylo_upd = add_digit7(ylo_r, dval);
        end
      end else begin
        fmt_upd = 1'b0;
      end
    end else if (pos_r == POS_DASH_A || pos_r == POS_DASH_B) begin
      if (char_code != CHAR_DASH) fmt_upd = 1'b0;
    end else if (pos_r == POS_SLASH) begin
      if (char_code != CHAR_SLASH) fmt_upd = 1'b0;
    end else if (pos_r == POS_COLON) begin
      if (char_code != CHAR_COLON) fmt_upd = 1'b0;
    end else if (pos_r < POS_TEXT_LEN) begin
      if (!digit) begin
        fmt_upd = 1'b0;
      end else if (pos_r <= POS_MONTH_END) begin
        month_upd = add_digit7(month_r, dval);
      end else if (pos_r <= POS_DAY_END) begin
        day_upd = add_digit7(day_r, dval);
      end else if (pos_r <= POS_HOUR_END) begin
        hour_upd = add_digit7(hour_r, dval);
      end else begin
        minute_upd = add_digit7(minute_r, dval);
      end
    end else begin
      fmt_upd = 1'b0;
    end
  end

  // next state: hold, update, or clear after the final character
  always_comb begin
    pos_nxt    = pos_r;
    fmt_nxt    = fmt_r;
    year_nxt   = year_r;
    yhi_nxt    = yhi_r;
    ylo_nxt    = ylo_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    if (take) begin
      if (last_char) begin
        pos_nxt    = '0;
        fmt_nxt    = 1'b1;
        year_nxt   = '0;
        yhi_nxt    = '0;
        ylo_nxt    = '0;
        month_nxt  = '0;
        day_nxt    = '0;
        hour_nxt   = '0;
        minute_nxt = '0;
      end else begin
        if (pos_r < POS_SAT) pos_nxt = pos_r + 1'b1;
        fmt_nxt    = fmt_upd;
        year_nxt   = year_upd;
        yhi_nxt    = yhi_upd;
        ylo_nxt    = ylo_upd;
        month_nxt  = month_upd;
        day_nxt    = day_upd;
        hour_nxt   = hour_upd;
        minute_nxt = minute_upd;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      fmt_r    <= 1'b1;
      year_r   <= '0;
      yhi_r    <= '0;
      ylo_r    <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      fmt_r    <= fmt_nxt;
      year_r   <= year_nxt;
      yhi_r    <= yhi_nxt;
      ylo_r    <= ylo_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
    end
  end

  // fields as they stand once this character is counted
  always_comb begin
    fields.fmt_ok  = fmt_upd;
    fields.len_ok  = (pos_r == POS_FINAL);
    fields.year    = year_upd;
    fields.year_hi = yhi_upd;
    fields.year_lo = ylo_upd;
    fields.month   = month_upd;
    fields.day     = day_upd;
    fields.hour    = hour_upd;
    fields.minute  = minute_upd;
  end

endmodule

// File: hdl/dtpv_check.sv
// calendar validation and the result register
module dtpv_check (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              out_taken,
  input  dtpv_pkg::fields_t fields,
  output logic              res_vld,
  output dtpv_pkg::result_t res
);
  import dtpv_pkg::*;

  logic       leap;
  logic [4:0] mdays;
  logic       ok;
  result_t    res_r, res_nxt;
  logic       vld_r, vld_nxt;

  // gregorian leap year from the two digit pairs of the year
  assign leap = (fields.year_lo[1:0] == 2'b00) &&
                !((fields.year_lo == 7'd0) && (fields.year_hi[1:0] != 2'b00));
  assign mdays = month_days(fields.month[3:0], leap);

  // all checks together
  always_comb begin
    ok = fields.fmt_ok && fields.len_ok &&
         (fields.year >= YEAR_MIN) && (fields.year <= YEAR_MAX) &&
         (fields.minute < MINUTE_LIM) && (fields.hour < HOUR_LIM) &&
         (fields.month != 7'd0) && (fields.month <= MONTH_MAX) &&
         (fields.day != 7'd0) && (fields.day <= {2'b00, mdays});
  end

  // result payload, zero when invalid
  always_comb begin
    res_nxt = res_r;
    if (load) begin
      res_nxt.valid_res = ok;
      res_nxt.year      = ok ? fields.year : '0;
      res_nxt.month     = ok ? fields.month[3:0] : '0;
      res_nxt.day       = ok ? fields.day[4:0] : '0;
      res_nxt.hour      = ok ? fields.hour[4:0] : '0;
      res_nxt.minute    = ok ? fields.minute[5:0] : '0;
    end
  end

  // result valid flag
  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_taken) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_vld = vld_r;
  assign res     = res_r;

endmodule

// File: hdl/date_text_parse_validate_unit.sv
// top level of the timestamp text parser and calendar validator
//
// Takes "YYYY-MM-DD/HH:MM" one ASCII character per request on the in_ stream
// and returns one result on the out_ stream for each character marked with
// in_tlast. A character is taken every clock cycle while no final character
// waits on the output side; it passes through the input register, and the
// result of a final character is then loaded into the output register.
// Characters without in_tlast produce no result and never wait on the output
// side; a final character waits only while the previous result is still
// unread. out_tuser is 1 when the text is well formed, 16 characters long
// and a real calendar date and time; otherwise it is 0 with all fields zero.
module date_text_parse_validate_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [13:0] year, [17:14] month, [22:18] day,
                                  // [27:23] hour, [33:28] minute, [39:34] zero
  output logic        out_tuser   // valid_res
);
  import dtpv_pkg::*;

  logic              in_vld_r, in_vld_nxt;
  logic [7:0]        char_r;
  logic              last_r;
  logic              out_free;
  logic              advance;
  fields_t           fields;
  result_t           res;

  // a final character needs a free result slot, others pass freely
  assign out_free  = !out_tvalid || out_tready;
  assign advance   = in_vld_r && (!last_r || out_free);
  assign in_tready = !in_vld_r || advance;

  // input register
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_tready) in_vld_nxt = in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      char_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  // character parser
  dtpv_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (advance),
    .char_code (char_r),
    .last_char (last_r),
    .fields    (fields)
  );

  // validation and result register
  dtpv_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && last_r),
    .out_taken (out_tready),
    .fields    (fields),
    .res_vld   (out_tvalid),
    .res       (res)
  );

  // result packing
  assign out_tuser = res.valid_res;
  assign out_tdata = {{(OUT_DATA_W - 34){1'b0}}, res.minute, res.hour, res.day,
                      res.month, res.year};

endmodule

// File: hdl/dtpv_checker.sv
// port-level assertions for the timestamp parser, bound to the top level
module dtpv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a rejected timestamp carries all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 40'd0)
    else $error("invalid result with nonzero fields");

  // an accepted timestamp has in-range fields
  a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[13:0] >= 14'd1000 && out_tdata[13:0] <= 14'd9999 &&
      out_tdata[17:14] != 4'd0 && out_tdata[17:14] <= 4'd12 &&
      out_tdata[22:18] != 5'd0 && out_tdata[27:23] < 5'd24 &&
      out_tdata[33:28] < 6'd60 && out_tdata[39:34] == 6'd0)
    else $error("valid result with out-of-range field");

  // thirty-first days only in long months
  a_short_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser &&
      (out_tdata[17:14] == 4'd2 || out_tdata[17:14] == 4'd4 || out_tdata[17:14] == 4'd6 ||
       out_tdata[17:14] == 4'd9 || out_tdata[17:14] == 4'd11) |->
      out_tdata[22:18] <= 5'd30 && (out_tdata[17:14] != 4'd2 || out_tdata[22:18] <= 5'd29))
    else $error("day beyond month length");

endmodule

bind date_text_parse_validate_unit dtpv_checker u_dtpv_checker (.*);

// File: dv/tb_date_text_parse_validate_unit.sv
// testbench of the timestamp parser: directed stamp table, random stamps, result scoreboard
module tb_date_text_parse_validate_unit;
  import dtpv_pkg::*;

  localparam int PRED        = -1;   // row result comes from the parse predictor
  localparam int DIR_ROWS    = 25;
  localparam int RAND_CHARS  = 400;
  localparam int RAND_STAMPS = 24;
  localparam int MAX_SHOWN   = 10;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] char_code
  logic        in_tlast   = 1'b0;   // last_char
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;           // year, month, day, hour, minute, zero pad
  logic        out_tuser;           // valid_res

  date_text_parse_validate_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // directed stamps; first column 1/0 is a typed result, PRED defers to the predictor
  string dir_txt [DIR_ROWS] = '{
    "1000-01-01/00:00", "9999-12-31/23:59", "2024-02-29/23:59", "2000-02-29/12:00",
    "1900-02-29/12:00", "2023-02-29/00:00", "0999-06-15/10:10", "2024-00-10/10:10",
    "2024-13-10/10:10", "2024-04-00/10:10", "2024-04-31/10:10", "2024-04-30/24:00",
    "2024-04-30/23:60", "2024-04-30 23:59", "2024-4A-30/23:59", "2024-04-30/23:5",
    "2024-04-30/23:590", "2024-01-01/00:00:00:00", "7", "9999-99-99/99:99",
    "0000-00-00/00:00", "2024-01-01/00:0\377", "2100-02-28/23:59", "1996-02-29/07:05",
    "2024-11-30/18:45"
  };
  int dir_want [DIR_ROWS][6] = '{
    '{1, 1000, 1, 1, 0, 0}, '{1, 9999, 12, 31, 23, 59}, '{1, 2024, 2, 29, 23, 59},
    '{1, 2000, 2, 29, 12, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0}, '{PRED, 0, 0, 0, 0, 0}, '{PRED, 0, 0, 0, 0, 0},
    '{PRED, 0, 0, 0, 0, 0}
  };

  // parse predictor state
  logic [4:0]  ps_pos  = '0;
  logic        ps_ok   = 1'b1;
  logic [13:0] ps_year = '0;
  logic [6:0]  ps_mon  = '0;
  logic [6:0]  ps_day  = '0;
  logic [6:0]  ps_hour = '0;
  logic [6:0]  ps_min  = '0;

  result_t    due_stamps [$];   // parsed stamps still owed by the block
  logic [7:0] stamp_q [$];      // characters of the stamp being sent
  int         fails      = 0;
  int         char_count = 0;
  int         burst_left = 0;
  int         ready_pct  = 100;
  int         ready_span = 0;

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // days in a month, zero for codes that are no month
  function automatic int days_in(input logic [6:0] m, input logic [13:0] y);
    bit leap;
    leap = (y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0));
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      MONTH_FEB:             return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // advance the predictor by one character, yields a parsed stamp on the final one
  task automatic parse_step(input logic [7:0] c, input logic fin,
                            output bit done, output result_t r);
    bit         dig;
    bit         good;
    logic [3:0] d;
    logic [4:0] at;
    dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    d   = dig ? 4'(c - CHAR_ZERO) : 4'd0;
    at  = ps_pos;
    if (at <= POS_YEAR_END) begin
      if (dig) ps_year = 14'(ps_year * 10 + d);
      else ps_ok = 1'b0;
    end else if (at == POS_DASH_A || at == POS_DASH_B) begin
      if (c != CHAR_DASH) ps_ok = 1'b0;
    end else if (at == POS_SLASH) begin
      if (c != CHAR_SLASH) ps_ok = 1'b0;
    end else if (at == POS_COLON) begin
      if (c != CHAR_COLON) ps_ok = 1'b0;
    end else if (at < POS_TEXT_LEN) begin
      // rejected characters are not accumulated
      if (!dig) ps_ok = 1'b0;
      else if (at <= POS_MONTH_END) ps_mon = 7'(ps_mon * 10 + d);
      else if (at <= POS_DAY_END) ps_day = 7'(ps_day * 10 + d);
      else if (at <= POS_HOUR_END) ps_hour = 7'(ps_hour * 10 + d);
      else ps_min = 7'(ps_min * 10 + d);
    end else begin
      ps_ok = 1'b0;
    end
    if (ps_pos < POS_SAT) ps_pos = at + 5'd1;
    done = fin;
    r    = '0;
    if (fin) begin
      good = ps_ok && (at == POS_FINAL);
      if (ps_year < YEAR_MIN || ps_year > YEAR_MAX) good = 1'b0;
      if (ps_min >= MINUTE_LIM || ps_hour >= HOUR_LIM) good = 1'b0;
      if (ps_mon < 1 || ps_mon > MONTH_MAX) good = 1'b0;
      if (ps_day < 1 || ps_day > days_in(ps_mon, ps_year)) good = 1'b0;
      if (good) begin
        r.valid_res = 1'b1;
        r.year      = ps_year;
        r.month     = ps_mon[3:0];
        r.day       = ps_day[4:0];
        r.hour      = ps_hour[4:0];
        r.minute    = ps_min[5:0];
      end
      // back to the reset state for the next stamp
      ps_pos  = '0;
      ps_ok   = 1'b1;
      ps_year = '0;
      ps_mon  = '0;
      ps_day  = '0;
      ps_hour = '0;
      ps_min  = '0;
    end
  endtask

  // one character request, sent in bursts with random gaps between them
  task automatic put_char(input logic [7:0] c, input logic fin,
                          input bit use_fixed, input result_t fixed_r);
    int      idle_n;
    bit      done;
    result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      idle_n     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (idle_n != 0) begin
        in_tvalid <= 1'b0;
        repeat (idle_n) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    char_count++;
    parse_step(c, fin, done, r);
    if (done) due_stamps.push_back(use_fixed ? fixed_r : r);
  endtask

  // send the buffered stamp, final character marked
  task automatic send_stamp(input bit use_fixed, input result_t fixed_r);
    int k;
    for (k = 0; k < stamp_q.size(); k++)
      put_char(stamp_q[k], k == stamp_q.size() - 1, use_fixed, fixed_r);
  endtask

  // hold the sender until every owed result has come back
  task automatic drain_wait();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (due_stamps.size() != 0);
  endtask

  // append a decimal number of n digits
  task automatic push_num(input int v, input int n);
    int dv;
    int k;
    dv = 1;
    for (k = 1; k < n; k++) dv = dv * 10;
    for (k = 0; k < n; k++) begin
      stamp_q.push_back(8'(CHAR_ZERO + (v / dv) % 10));
      dv = dv / 10;
    end
  endtask

  // random stamp: mostly well formed with calendar edges, some damaged or noise
  task automatic make_stamp();
    int yr;
    int mo;
    int dy;
    int hr;
    int mi;
    int pick;
    int n;
    int k;
    pick = $urandom_range(0, 9);
    if (pick == 0) yr = $urandom_range(0, 999);
    else if (pick == 1) yr = 400 * $urandom_range(3, 24) + 100 * $urandom_range(0, 3);
    else yr = $urandom_range(1000, 9999);
    pick = $urandom_range(0, 9);
    if (pick == 0) mo = $urandom_range(0, 99);
    else if (pick == 1) mo = $urandom_range(0, 1) ? 13 : 0;
    else if (pick <= 3) mo = MONTH_FEB;
    else mo = $urandom_range(1, 12);
    pick = $urandom_range(0, 9);
    if (pick == 0) dy = $urandom_range(0, 99);
    else if (pick <= 4) dy = $urandom_range(28, 31);
    else dy = $urandom_range(1, 31);
    hr = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 99) : $urandom_range(0, 23);
    mi = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
    stamp_q.delete();
    push_num(yr, 4);
    stamp_q.push_back(CHAR_DASH);
    push_num(mo, 2);
    stamp_q.push_back(CHAR_DASH);
    push_num(dy, 2);
    stamp_q.push_back(CHAR_SLASH);
    push_num(hr, 2);
    stamp_q.push_back(CHAR_COLON);
    push_num(mi, 2);
    // damage a share of the stamps
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      stamp_q[$urandom_range(0, 15)] = 8'($urandom_range(0, 255));
    end else if (pick < 17) begin
      n = $urandom_range(1, 15);
      for (k = 0; k < n; k++) void'(stamp_q.pop_back());
    end else if (pick < 24) begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) stamp_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 30) begin
      stamp_q.delete();
      n = $urandom_range(1, 20);
      for (k = 0; k < n; k++) stamp_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // log one bad result
  task automatic note_miss(input string what, input result_t w, input result_t g,
                           input logic [5:0] pad);
    fails++;
    if (fails <= MAX_SHOWN)
      $display("%s at %0t: want v=%0d y=%0d m=%0d d=%0d h=%0d mi=%0d,",
               what, $time, w.valid_res, w.year, w.month, w.day, w.hour, w.minute,
               " got v=%0d y=%0d m=%0d d=%0d h=%0d mi=%0d pad=%0h",
               g.valid_res, g.year, g.month, g.day, g.hour, g.minute, pad);
  endtask

  // result receiver with its own stall pattern
  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_span = $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0:       ready_pct = 100;
        1:       ready_pct = 70;
        2:       ready_pct = 35;
        default: ready_pct = 8;
      endcase
    end
    ready_span--;
    out_tready <= ($urandom_range(1, 100) <= ready_pct);
  end

  // scoreboard: compare each accepted result with the oldest owed stamp
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.valid_res = out_tuser;
      seen.year      = out_tdata[13:0];
      seen.month     = out_tdata[17:14];
      seen.day       = out_tdata[22:18];
      seen.hour      = out_tdata[27:23];
      seen.minute    = out_tdata[33:28];
      if (due_stamps.size() == 0) begin
        note_miss("unexpected result", '0, seen, out_tdata[39:34]);
      end else begin
        want = due_stamps.pop_front();
        if (seen !== want || out_tdata[39:34] !== 6'd0)
          note_miss("result mismatch", want, seen, out_tdata[39:34]);
      end
    end
  end

  // stimulus: directed table, then random stamps
  initial begin
    int      i;
    int      k;
    int      s;
    result_t fixed_r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (i = 0; i < DIR_ROWS; i++) begin
      stamp_q.delete();
      for (k = 0; k < dir_txt[i].len(); k++) stamp_q.push_back(dir_txt[i][k]);
      fixed_r.valid_res = (dir_want[i][0] == 1);
      fixed_r.year      = 14'(dir_want[i][1]);
      fixed_r.month     = 4'(dir_want[i][2]);
      fixed_r.day       = 5'(dir_want[i][3]);
      fixed_r.hour      = 5'(dir_want[i][4]);
      fixed_r.minute    = 6'(dir_want[i][5]);
      send_stamp(dir_want[i][0] != PRED, fixed_r);
    end
    drain_wait();
    char_count = 0;
    for (s = 0; char_count < RAND_CHARS || s < RAND_STAMPS; s++) begin
      make_stamp();
      send_stamp(1'b0, '0);
      if (s % 9 == 8) drain_wait();
    end
    drain_wait();
    repeat (16) @(posedge clk);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
